FILE: rtl/core/bst_pkg.sv
`timescale 1ns / 1ps
// Package for the BASIC source tokenizer: request types, token codes,
// character codes, the keyword table and the helper functions.
// No dependencies.
package bst_pkg;

  localparam int TEXT_MAX  = 63;
  localparam int TEXT_BITS = TEXT_MAX * 8;
  localparam logic [7:0] COMMENT_SCAN_MAX = 8'd255;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_FRAC,
    MODE_STR,
    MODE_WORD,
    MODE_COMMENT,
    MODE_LESS,
    MODE_GREATER
  } mode_e;

  // Token kinds.
  localparam logic [6:0] TK_END     = 7'd0;
  localparam logic [6:0] TK_NEWLINE = 7'd1;
  localparam logic [6:0] TK_NUMBER  = 7'd2;
  localparam logic [6:0] TK_STRING  = 7'd3;
  localparam logic [6:0] TK_IDENT   = 7'd4;
  localparam logic [6:0] TK_KEYBASE = 7'd5;
  localparam logic [6:0] TK_REM     = 7'd23;
  localparam logic [6:0] TK_PLUS    = 7'd69;
  localparam logic [6:0] TK_MINUS   = 7'd70;
  localparam logic [6:0] TK_STAR    = 7'd71;
  localparam logic [6:0] TK_SLASH   = 7'd72;
  localparam logic [6:0] TK_CARET   = 7'd73;
  localparam logic [6:0] TK_LPAREN  = 7'd74;
  localparam logic [6:0] TK_RPAREN  = 7'd75;
  localparam logic [6:0] TK_COMMA   = 7'd76;
  localparam logic [6:0] TK_SEMI    = 7'd77;
  localparam logic [6:0] TK_COLON   = 7'd78;
  localparam logic [6:0] TK_EQ      = 7'd79;
  localparam logic [6:0] TK_LT      = 7'd80;
  localparam logic [6:0] TK_LE      = 7'd81;
  localparam logic [6:0] TK_NE      = 7'd82;
  localparam logic [6:0] TK_GT      = 7'd83;
  localparam logic [6:0] TK_GE      = 7'd84;

  // Character codes.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_US     = 8'h5F;

  // Keywords, right-justified: the last character sits in the low byte.
  localparam logic [47:0] KW_TABLE [64] = '{
    "PRINT", "LET", "IF", "THEN", "ELSE", "GOTO", "GOSUB", "RETURN",
    "FOR", "TO", "STEP", "NEXT", "WHILE", "WEND", "INPUT", "DIM",
    "END", "STOP", "REM", "LIST", "RUN", "NEW", "LOAD", "SAVE",
    "AND", "OR", "NOT", "MOD", "SQR", "INT", "ABS", "RND",
    "SIN", "COS", "TAN", "LOG", "EXP", "SGN", "ATN", "LEN",
    "MID$", "LEFT$", "RIGHT$", "STR$", "VAL", "CHR$", "ASC", "SCREEN",
    "CIRCLE", "LINE", "RECT", "COLOR", "CLEAR", "FLIP", "POINT", "TEXT",
    "SPRITE", "FILLED", "CLOSE", "DRAW", "FREE", "POLL", "MOUSE", "KEY"
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] source_byte;
  } in_t;

  typedef struct packed {
    logic [6:0]  token_kind;
    logic [5:0]  text_length;
    logic [63:0] text_word0;
    logic [63:0] text_word1;
    logic [63:0] text_word2;
    logic [63:0] text_word3;
    logic [63:0] text_word4;
    logic [63:0] text_word5;
    logic [63:0] text_word6;
    logic [55:0] text_word7;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    mode_e      mode;
    logic [5:0] cnt;
    logic [7:0] scan;
  } scan_t;

  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_idx;
    logic [7:0] wr_byte;
    logic [1:0] res_n;
  } step_ctl_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_US) || (b == CH_DOLLAR);
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) ? b - 8'h20 : b;
  endfunction

  function automatic logic [5:0] kw_len(logic [47:0] w);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 6; i++) begin
      if (w[8*i +: 8] != 8'h00) n = n + 6'd1;
    end
    return n;
  endfunction

  // The word is packed right-justified like the table entries.
  function automatic logic [6:0] kw_lookup(logic [47:0] w, logic [5:0] len);
    logic [6:0] k;
    k = TK_IDENT;
    for (int i = 0; i < 64; i++) begin
      if ((w == KW_TABLE[i]) && (len == kw_len(KW_TABLE[i]))) begin
        k = TK_KEYBASE + 7'(i);
      end
    end
    return k;
  endfunction

  function automatic out_t make_result(logic [6:0] kind, logic [5:0] len,
                                       logic [TEXT_BITS-1:0] text);
    out_t r;
    r.token_kind  = kind;
    r.text_length = len;
    r.text_word0  = text[0   +: 64];
    r.text_word1  = text[64  +: 64];
    r.text_word2  = text[128 +: 64];
    r.text_word3  = text[192 +: 64];
    r.text_word4  = text[256 +: 64];
    r.text_word5  = text[320 +: 64];
    r.text_word6  = text[384 +: 64];
    r.text_word7  = text[448 +: 56];
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/core/bst_step.sv
`timescale 1ns / 1ps
// Next-state and token logic of the tokenizer for one request.
// Depends on bst_pkg.
module bst_step import bst_pkg::*; (
  input  in_t                  item_i,
  input  scan_t                st_i,
  input  logic [TEXT_BITS-1:0] text_i,
  output scan_t                st_o,
  output step_ctl_t            ctl_o,
  output out_t                 res0_o,
  output out_t                 res1_o
);

  logic [7:0]           b;
  logic [TEXT_BITS-1:0] bufm;
  logic [47:0]          wpack;
  logic [6:0]           kw;
  logic                 room;
  logic                 fresh_req;
  logic [1:0]           n;
  out_t                 res [2];

  assign b    = item_i.source_byte;
  assign room = st_i.cnt < 6'(TEXT_MAX);

  // Buffer with the bytes past the count forced to zero.
  always_comb begin
    for (int i = 0; i < TEXT_MAX; i++) begin
      bufm[8*i +: 8] = (6'(i) < st_i.cnt) ? text_i[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    wpack = '0;
    for (int i = 0; i < 6; i++) begin
      if (6'(i) < st_i.cnt) wpack = {wpack[39:0], text_i[8*i +: 8]};
    end
  end

  assign kw = kw_lookup(wpack, st_i.cnt);

  always_comb begin
    st_o          = st_i;
    ctl_o.wr_en   = 1'b0;
    ctl_o.wr_idx  = st_i.cnt;
    ctl_o.wr_byte = b;
    fresh_req     = 1'b0;
    n             = '0;
    res[0]        = make_result(TK_END, '0, '0);
    res[1]        = make_result(TK_END, '0, '0);

    if (item_i.kind) begin
      // End of source: flush, then the end token.
      case (st_i.mode)
        MODE_INT, MODE_FRAC: begin
          res[n[0]] = make_result(TK_NUMBER, st_i.cnt, bufm); n = n + 2'd1;
        end
        MODE_STR: begin
          res[n[0]] = make_result(TK_STRING, st_i.cnt, bufm); n = n + 2'd1;
        end
        MODE_WORD: begin
          if (kw == TK_REM) res[n[0]] = make_result(TK_REM, '0, '0);
          else res[n[0]] = make_result(kw, st_i.cnt, bufm);
          n = n + 2'd1;
        end
        MODE_COMMENT: begin
          res[n[0]] = make_result(TK_REM, st_i.cnt, bufm); n = n + 2'd1;
        end
        MODE_LESS: begin
          res[n[0]] = make_result(TK_LT, 6'd1, TEXT_BITS'(CH_LT)); n = n + 2'd1;
        end
        MODE_GREATER: begin
          res[n[0]] = make_result(TK_GT, 6'd1, TEXT_BITS'(CH_GT)); n = n + 2'd1;
        end
        default: ;
      endcase
      res[n[0]] = make_result(TK_END, '0, '0);
      n         = n + 2'd1;
      st_o.mode = MODE_IDLE;
      st_o.cnt  = '0;
      st_o.scan = '0;
    end else begin
      unique case (st_i.mode)
        MODE_IDLE: fresh_req = 1'b1;
        MODE_INT: begin
          if (is_digit(b) && room) begin
            ctl_o.wr_en = 1'b1;
            st_o.cnt    = st_i.cnt + 6'd1;
          end else if (b == CH_DOT) begin
            if (room) begin
              ctl_o.wr_en = 1'b1;
              st_o.cnt    = st_i.cnt + 6'd1;
              st_o.mode   = MODE_FRAC;
            end else begin
              res[n[0]] = make_result(TK_NUMBER, st_i.cnt, bufm); n = n + 2'd1;
              st_o.mode = MODE_IDLE;
              st_o.cnt  = '0;
            end
          end else begin
            res[n[0]] = make_result(TK_NUMBER, st_i.cnt, bufm); n = n + 2'd1;
            fresh_req = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(b) && room) begin
            ctl_o.wr_en = 1'b1;
            st_o.cnt    = st_i.cnt + 6'd1;
          end else begin
            res[n[0]] = make_result(TK_NUMBER, st_i.cnt, bufm); n = n + 2'd1;
            fresh_req = 1'b1;
          end
        end
        MODE_STR: begin
          if (b == CH_QUOTE) begin
            res[n[0]] = make_result(TK_STRING, st_i.cnt, bufm); n = n + 2'd1;
            st_o.mode = MODE_IDLE;
            st_o.cnt  = '0;
          end else if (room) begin
            ctl_o.wr_en = 1'b1;
            st_o.cnt    = st_i.cnt + 6'd1;
          end else begin
            res[n[0]] = make_result(TK_STRING, st_i.cnt, bufm); n = n + 2'd1;
            fresh_req = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_word(b) && room) begin
            ctl_o.wr_en   = 1'b1;
            ctl_o.wr_byte = upcase(b);
            st_o.cnt      = st_i.cnt + 6'd1;
          end else if (kw == TK_REM) begin
            // REM opens a comment, and this byte is its first unless it is a newline.
            if (b == CH_NL) begin
              res[n[0]] = make_result(TK_REM, '0, '0); n = n + 2'd1;
              fresh_req = 1'b1;
            end else begin
              st_o.mode    = MODE_COMMENT;
              ctl_o.wr_en  = 1'b1;
              ctl_o.wr_idx = '0;
              st_o.cnt     = 6'd1;
              st_o.scan    = 8'd1;
            end
          end else begin
            res[n[0]] = make_result(kw, st_i.cnt, bufm); n = n + 2'd1;
            fresh_req = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if ((b == CH_NL) || (st_i.scan == COMMENT_SCAN_MAX)) begin
            res[n[0]] = make_result(TK_REM, st_i.cnt, bufm); n = n + 2'd1;
            fresh_req = 1'b1;
          end else begin
            if (room) begin
              ctl_o.wr_en = 1'b1;
              st_o.cnt    = st_i.cnt + 6'd1;
            end
            st_o.scan = st_i.scan + 8'd1;
          end
        end
        MODE_LESS: begin
          st_o.mode = MODE_IDLE;
          st_o.cnt  = '0;
          if (b == CH_EQ) begin
            res[n[0]] = make_result(TK_LE, 6'd2, TEXT_BITS'({CH_EQ, CH_LT}));
            n = n + 2'd1;
          end else if (b == CH_GT) begin
            res[n[0]] = make_result(TK_NE, 6'd2, TEXT_BITS'({CH_GT, CH_LT}));
            n = n + 2'd1;
          end else begin
            res[n[0]] = make_result(TK_LT, 6'd1, TEXT_BITS'(CH_LT)); n = n + 2'd1;
            fresh_req = 1'b1;
          end
        end
        MODE_GREATER: begin
          st_o.mode = MODE_IDLE;
          st_o.cnt  = '0;
          if (b == CH_EQ) begin
            res[n[0]] = make_result(TK_GE, 6'd2, TEXT_BITS'({CH_EQ, CH_GT}));
            n = n + 2'd1;
          end else begin
            res[n[0]] = make_result(TK_GT, 6'd1, TEXT_BITS'(CH_GT)); n = n + 2'd1;
            fresh_req = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // A byte that starts from scratch, after any token it closed.
    if (fresh_req) begin
      st_o.mode = MODE_IDLE;
      st_o.cnt  = '0;
      if (b == CH_NL) begin
        res[n[0]] = make_result(TK_NEWLINE, '0, '0); n = n + 2'd1;
      end else if (is_space(b)) begin
        st_o.mode = MODE_IDLE;
      end else if (is_digit(b)) begin
        st_o.mode    = MODE_INT;
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_idx = '0;
        st_o.cnt     = 6'd1;
      end else if (b == CH_QUOTE) begin
        st_o.mode = MODE_STR;
      end else if (is_alpha(b)) begin
        st_o.mode     = MODE_WORD;
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_idx  = '0;
        ctl_o.wr_byte = upcase(b);
        st_o.cnt      = 6'd1;
      end else if (b == CH_LT) begin
        st_o.mode = MODE_LESS;
      end else if (b == CH_GT) begin
        st_o.mode = MODE_GREATER;
      end else begin
        case (b)
          CH_PLUS:   begin res[n[0]] = make_result(TK_PLUS,   6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_MINUS:  begin res[n[0]] = make_result(TK_MINUS,  6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_STAR:   begin res[n[0]] = make_result(TK_STAR,   6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_SLASH:  begin res[n[0]] = make_result(TK_SLASH,  6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_CARET:  begin res[n[0]] = make_result(TK_CARET,  6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_LPAREN: begin res[n[0]] = make_result(TK_LPAREN, 6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_RPAREN: begin res[n[0]] = make_result(TK_RPAREN, 6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_COMMA:  begin res[n[0]] = make_result(TK_COMMA,  6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_SEMI:   begin res[n[0]] = make_result(TK_SEMI,   6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_COLON:  begin res[n[0]] = make_result(TK_COLON,  6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          CH_EQ:     begin res[n[0]] = make_result(TK_EQ,     6'd1, TEXT_BITS'(b)); n = n + 2'd1; end
          default: ;
        endcase
      end
    end

    if (n == 2'd1) res[0].last_of_run = 1'b1;
    if (n == 2'd2) res[1].last_of_run = 1'b1;
    ctl_o.res_n = n;
  end

  assign res0_o = res[0];
  assign res1_o = res[1];

endmodule

FILE: rtl/core/basic_source_tokenizer_core.sv
`timescale 1ns / 1ps
// Top level of the BASIC source tokenizer: scan state, token text buffer
// and a four-entry result queue. Depends on bst_pkg and bst_step.

// The tokenizer takes one source byte per cycle while not stalled and pushes
// the zero, one or two tokens that the byte finishes into a four-entry
// result queue, which sends one token per cycle unless out_stall_i holds it.
// A byte is taken whenever the queue holds two tokens or fewer, so input
// stall rises only when results back up. Since most bytes finish at most one
// token, the block sustains one byte per cycle while the output is not stalled;
// bytes that finish two tokens use the output port twice, which therefore
// limits the long-run byte rate. A token is written into the result queue when the byte that ends it is taken.
module basic_source_tokenizer_core import bst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  scan_t                st_q, st_d;
  logic [TEXT_BITS-1:0] text_q;
  step_ctl_t            ctl;
  out_t                 res0, res1;
  out_t                 fifo_q [4];
  logic [1:0]           wptr_q, rptr_q;
  logic [2:0]           fcnt_q;
  logic                 in_acc, out_acc;
  logic [1:0]           push_n;

  bst_step u_step (
    .item_i (in_data_i),
    .st_i   (st_q),
    .text_i (text_q),
    .st_o   (st_d),
    .ctl_o  (ctl),
    .res0_o (res0),
    .res1_o (res1)
  );

  assign in_stall_o  = fcnt_q > 3'd2;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = fcnt_q != 3'd0;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_data_o  = fifo_q[rptr_q];
  assign push_n      = in_acc ? ctl.res_n : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode <= MODE_IDLE;
      st_q.cnt  <= '0;
      st_q.scan <= '0;
      wptr_q    <= '0;
      rptr_q    <= '0;
      fcnt_q    <= '0;
    end else begin
      if (in_acc) st_q <= st_d;
      wptr_q <= wptr_q + push_n;
      if (out_acc) rptr_q <= rptr_q + 2'd1;
      fcnt_q <= fcnt_q + {1'b0, push_n} - {2'b00, out_acc};
    end
  end

  // Token text and queue entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc && ctl.wr_en) text_q[8*ctl.wr_idx +: 8] <= ctl.wr_byte;
    if (push_n != 2'd0) fifo_q[wptr_q] <= res0;
    if (push_n == 2'd2) fifo_q[wptr_q + 2'd1] <= res1;
  end

endmodule

FILE: dv/tb_basic_source_tokenizer_core.sv
`timescale 1ns / 1ps
// Testbench for basic_source_tokenizer_core: a table of directed source bytes,
// then random token-shaped source, checked against a token predictor.
// Depends on bst_pkg and the tokenizer RTL.
module tb_basic_source_tokenizer_core;
  import bst_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] b;
    logic       chk;
    logic [6:0] want;
  } row_t;

  localparam int NROWS = 28;
  localparam row_t DIRECTED [NROWS] = '{
    '{1'b0, "r", 1'b0, TK_END}, '{1'b0, "e", 1'b0, TK_END},
    '{1'b0, "m", 1'b0, TK_END}, '{1'b0, " ", 1'b0, TK_END},
    '{1'b0, 8'h00, 1'b0, TK_END}, '{1'b0, CH_NL, 1'b1, TK_NEWLINE},
    '{1'b0, "I", 1'b0, TK_END}, '{1'b0, "f", 1'b0, TK_END},
    '{1'b0, " ", 1'b1, TK_KEYBASE + 7'd2},
    '{1'b0, "9", 1'b0, TK_END}, '{1'b0, CH_DOT, 1'b0, TK_END},
    '{1'b0, "5", 1'b0, TK_END}, '{1'b0, CH_DOT, 1'b1, TK_NUMBER},
    '{1'b0, CH_LT, 1'b0, TK_END}, '{1'b0, CH_GT, 1'b1, TK_NE},
    '{1'b0, CH_GT, 1'b0, TK_END}, '{1'b0, CH_EQ, 1'b1, TK_GE},
    '{1'b0, CH_QUOTE, 1'b0, TK_END}, '{1'b0, 8'hFF, 1'b0, TK_END},
    '{1'b0, CH_QUOTE, 1'b1, TK_STRING},
    '{1'b0, "a", 1'b0, TK_END}, '{1'b0, CH_DOLLAR, 1'b0, TK_END},
    '{1'b0, CH_LT, 1'b1, TK_IDENT}, '{1'b0, CH_EQ, 1'b1, TK_LE},
    '{1'b0, "R", 1'b0, TK_END}, '{1'b0, "E", 1'b0, TK_END},
    '{1'b0, "M", 1'b0, TK_END}, '{1'b1, 8'h00, 1'b1, TK_END}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  basic_source_tokenizer_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Token predictor state.
  mode_e      scan_mode;
  logic [7:0] tok_buf [TEXT_MAX];
  int         tok_len;
  int         cmt_scanned;
  out_t       step_tokens[$];
  out_t       token_q[$];
  in_t        source_q[$];
  int         errors = 0;
  bit         calm_in = 0;
  bit         calm_out = 0;

  function automatic bit digit_c(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic [7:0] upper_c(logic [7:0] b);
    return (b >= "a" && b <= "z") ? b - 8'h20 : b;
  endfunction

  function automatic void post_token(logic [6:0] k, int n);
    logic [TEXT_BITS-1:0] bits;
    out_t r;
    bits = '0;
    for (int i = 0; i < n; i++) bits[8*i +: 8] = tok_buf[i];
    r.token_kind  = k;
    r.text_length = 6'(n);
    r.text_word0  = bits[0 +: 64];
    r.text_word1  = bits[64 +: 64];
    r.text_word2  = bits[128 +: 64];
    r.text_word3  = bits[192 +: 64];
    r.text_word4  = bits[256 +: 64];
    r.text_word5  = bits[320 +: 64];
    r.text_word6  = bits[384 +: 64];
    r.text_word7  = bits[448 +: 56];
    r.last_of_run = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function automatic void flush_text(logic [6:0] k);
    post_token(k, tok_len);
    tok_len = 0;
    scan_mode = MODE_IDLE;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    if (tok_len < TEXT_MAX) begin
      tok_buf[tok_len] = b;
      tok_len++;
    end
  endfunction

  function automatic void post_op(logic [6:0] k, logic [7:0] a, logic [7:0] c, int n);
    tok_buf[0] = a;
    tok_buf[1] = c;
    post_token(k, n);
    scan_mode = MODE_IDLE;
    tok_len = 0;
  endfunction

  // Words of up to six characters are packed right-justified to match the table.
  function automatic logic [6:0] word_kind();
    logic [47:0] w;
    w = '0;
    if (tok_len > 6) return TK_IDENT;
    for (int i = 0; i < tok_len; i++) w = {w[39:0], tok_buf[i]};
    for (int i = 0; i < 64; i++) begin
      if (w == KW_TABLE[i]) return TK_KEYBASE + 7'(i);
    end
    return TK_IDENT;
  endfunction

  function automatic void close_word();
    logic [6:0] k;
    k = word_kind();
    if (k == TK_REM) begin
      scan_mode = MODE_COMMENT;
      tok_len = 0;
      cmt_scanned = 0;
    end else begin
      flush_text(k);
    end
  endfunction

  function automatic void start_token(logic [7:0] b);
    scan_mode = MODE_IDLE;
    tok_len = 0;
    if (b == CH_NL) post_token(TK_NEWLINE, 0);
    else if (b == " " || (b >= 8'h09 && b <= 8'h0D)) ;
    else if (digit_c(b)) begin
      scan_mode = MODE_INT;
      add_byte(b);
    end else if (b == CH_QUOTE) scan_mode = MODE_STR;
    else if (alpha_c(b)) begin
      scan_mode = MODE_WORD;
      add_byte(upper_c(b));
    end else if (b == CH_LT) scan_mode = MODE_LESS;
    else if (b == CH_GT) scan_mode = MODE_GREATER;
    else begin
      case (b)
        CH_PLUS:   post_op(TK_PLUS, b, 8'h00, 1);
        CH_MINUS:  post_op(TK_MINUS, b, 8'h00, 1);
        CH_STAR:   post_op(TK_STAR, b, 8'h00, 1);
        CH_SLASH:  post_op(TK_SLASH, b, 8'h00, 1);
        CH_CARET:  post_op(TK_CARET, b, 8'h00, 1);
        CH_LPAREN: post_op(TK_LPAREN, b, 8'h00, 1);
        CH_RPAREN: post_op(TK_RPAREN, b, 8'h00, 1);
        CH_COMMA:  post_op(TK_COMMA, b, 8'h00, 1);
        CH_SEMI:   post_op(TK_SEMI, b, 8'h00, 1);
        CH_COLON:  post_op(TK_COLON, b, 8'h00, 1);
        CH_EQ:     post_op(TK_EQ, b, 8'h00, 1);
        default: ;
      endcase
    end
  endfunction

  function automatic void comment_step(logic [7:0] b);
    if (b == CH_NL || cmt_scanned >= int'(COMMENT_SCAN_MAX)) begin
      flush_text(TK_REM);
      start_token(b);
    end else begin
      add_byte(b);
      cmt_scanned++;
    end
  endfunction

  function automatic void clear_scan();
    scan_mode = MODE_IDLE;
    tok_len = 0;
    cmt_scanned = 0;
  endfunction

  function automatic void predict_tokens(in_t r);
    logic [7:0] b;
    b = r.source_byte;
    step_tokens.delete();
    if (r.kind) begin
      case (scan_mode)
        MODE_INT, MODE_FRAC: flush_text(TK_NUMBER);
        MODE_STR: flush_text(TK_STRING);
        MODE_WORD: begin
          close_word();
          if (scan_mode == MODE_COMMENT) flush_text(TK_REM);
        end
        MODE_COMMENT: flush_text(TK_REM);
        MODE_LESS: post_op(TK_LT, CH_LT, 8'h00, 1);
        MODE_GREATER: post_op(TK_GT, CH_GT, 8'h00, 1);
        default: ;
      endcase
      post_token(TK_END, 0);
      clear_scan();
    end else begin
      case (scan_mode)
        MODE_INT: begin
          if (digit_c(b) && tok_len < TEXT_MAX) add_byte(b);
          else if (b == CH_DOT) begin
            // A point on a full number is dropped and the number ends.
            if (tok_len < TEXT_MAX) begin
              add_byte(b);
              scan_mode = MODE_FRAC;
            end else flush_text(TK_NUMBER);
          end else begin
            flush_text(TK_NUMBER);
            start_token(b);
          end
        end
        MODE_FRAC: begin
          if (digit_c(b) && tok_len < TEXT_MAX) add_byte(b);
          else begin
            flush_text(TK_NUMBER);
            start_token(b);
          end
        end
        MODE_STR: begin
          if (b == CH_QUOTE) flush_text(TK_STRING);
          else if (tok_len < TEXT_MAX) add_byte(b);
          else begin
            flush_text(TK_STRING);
            start_token(b);
          end
        end
        MODE_WORD: begin
          if ((alpha_c(b) || digit_c(b) || b == CH_US || b == CH_DOLLAR)
              && tok_len < TEXT_MAX) add_byte(upper_c(b));
          else begin
            close_word();
            if (scan_mode == MODE_COMMENT) comment_step(b);
            else start_token(b);
          end
        end
        MODE_COMMENT: comment_step(b);
        MODE_LESS: begin
          if (b == CH_EQ) post_op(TK_LE, CH_LT, CH_EQ, 2);
          else if (b == CH_GT) post_op(TK_NE, CH_LT, CH_GT, 2);
          else begin
            post_op(TK_LT, CH_LT, 8'h00, 1);
            start_token(b);
          end
        end
        MODE_GREATER: begin
          if (b == CH_EQ) post_op(TK_GE, CH_GT, CH_EQ, 2);
          else begin
            post_op(TK_GT, CH_GT, 8'h00, 1);
            start_token(b);
          end
        end
        default: start_token(b);
      endcase
    end
    if (step_tokens.size() != 0) step_tokens[$].last_of_run = 1'b1;
    foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
  endfunction

  // Random source, built token by token.
  function automatic void put_byte(logic [7:0] b);
    source_q.push_back('{1'b0, b});
  endfunction

  function automatic int run_len(int lo, int hi);
    return ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(lo, hi);
  endfunction

  function automatic void gen_token();
    string wchars, ops;
    int n, sel;
    logic [47:0] kw;
    wchars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_$";
    ops = "+-*/^(),;:=<>";
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      n = run_len(1, 6);
      if ($urandom_range(0, 9) == 0) n = TEXT_MAX;
      for (int i = 0; i < n; i++) put_byte(8'("0") + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1)) begin
        put_byte(CH_DOT);
        n = run_len(0, 4);
        for (int i = 0; i < n; i++) put_byte(8'("0") + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 4) == 0) put_byte(CH_DOT);
      end
    end else if (sel < 30) begin
      put_byte(CH_QUOTE);
      n = run_len(0, 8);
      for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) put_byte(CH_QUOTE);
    end else if (sel < 48) begin
      kw = KW_TABLE[$urandom_range(0, 63)];
      if ($urandom_range(0, 1)) begin
        for (int i = 5; i >= 0; i--) begin
          if (kw[8*i +: 8] != 8'h00)
            put_byte($urandom_range(0, 1) ? kw[8*i +: 8] : kw[8*i +: 8] + 8'h20);
        end
      end else begin
        put_byte(wchars[$urandom_range(0, 51)]);
        n = run_len(0, 7);
        for (int i = 0; i < n; i++) put_byte(wchars[$urandom_range(0, 63)]);
      end
    end else if (sel < 56) begin
      put_byte("R");
      put_byte($urandom_range(0, 1) ? "E" : "e");
      put_byte("M");
      // Now and then a comment long enough to hit the scan limit.
      n = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 262) : run_len(0, 10);
      for (int i = 0; i < n; i++) put_byte(8'($urandom_range(32, 126)));
      if ($urandom_range(0, 3) != 0) put_byte(CH_NL);
    end else if (sel < 78) begin
      put_byte(ops[$urandom_range(0, 12)]);
      if ($urandom_range(0, 2) == 0) put_byte($urandom_range(0, 1) ? CH_EQ : CH_GT);
    end else if (sel < 88) begin
      put_byte($urandom_range(0, 1) ? CH_NL : 8'($urandom_range(9, 13)));
      if ($urandom_range(0, 1)) put_byte(" ");
    end else if (sel < 96) begin
      put_byte(8'($urandom_range(0, 255)));
    end else begin
      source_q.push_back('{1'b1, 8'($urandom_range(0, 255))});
    end
  endfunction

  task automatic send_request(in_t r);
    int gap;
    if ($urandom_range(0, 49) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = r;
    do @(posedge clk_i); while (in_stall_o);
    predict_tokens(r);
    @(negedge clk_i);
  endtask

  function automatic void cmp(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  // Output side: compare each accepted token with the oldest prediction.
  bit took = 0;
  int hold = 0;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      took <= 1'b1;
      if (token_q.size() == 0) begin
        $error("token with none predicted: kind %0d", out_data_o.token_kind);
        errors++;
      end else begin
        out_t e;
        e = token_q.pop_front();
        cmp("token_kind", 64'(e.token_kind), 64'(out_data_o.token_kind));
        cmp("text_length", 64'(e.text_length), 64'(out_data_o.text_length));
        cmp("text_word0", e.text_word0, out_data_o.text_word0);
        cmp("text_word1", e.text_word1, out_data_o.text_word1);
        cmp("text_word2", e.text_word2, out_data_o.text_word2);
        cmp("text_word3", e.text_word3, out_data_o.text_word3);
        cmp("text_word4", e.text_word4, out_data_o.text_word4);
        cmp("text_word5", e.text_word5, out_data_o.text_word5);
        cmp("text_word6", e.text_word6, out_data_o.text_word6);
        cmp("text_word7", 64'(e.text_word7), 64'(out_data_o.text_word7));
        cmp("last_of_run", 64'(e.last_of_run), 64'(out_data_o.last_of_run));
      end
    end
  end

  always @(negedge clk_i) begin
    if (took) begin
      took <= 1'b0;
      if ($urandom_range(0, 49) == 0) calm_out = !calm_out;
      hold = calm_out ? 0 : $urandom_range(0, 11);
    end
    out_stall_i <= (hold != 0);
    if (hold != 0) hold--;
  end

  initial begin
    int waited;
    clear_scan();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < NROWS; i++) begin
      send_request('{DIRECTED[i].kind, DIRECTED[i].b});
      // A checked row must close a token of the listed kind as its last.
      if (DIRECTED[i].chk && (step_tokens.size() == 0 ||
          step_tokens[$].token_kind != DIRECTED[i].want)) begin
        $error("directed row %0d: expected token_kind %0d, predicted none or other",
               i, DIRECTED[i].want);
        errors++;
      end
    end
    while (source_q.size() < 1850) gen_token();
    source_q.push_back('{1'b1, 8'h00});
    foreach (source_q[i]) send_request(source_q[i]);
    in_valid_i = 1'b0;
    waited = 0;
    while (token_q.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(negedge clk_i);
    if (errors == 0 && token_q.size() == 0) begin
      $display("PASS basic_source_tokenizer_core");
    end else begin
      $display("FAIL basic_source_tokenizer_core");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL basic_source_tokenizer_core");
    $finish;
  end

endmodule
